FILE: rtl/prpf_pkg.sv
// prpf_pkg: shared constants and types for the printable run pattern filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package prpf_pkg;

	// sizes of the image offset and the run counter
	localparam int OFFSET_BITS    = 32;
	localparam int MAX_RUN_LENGTH = 64;
	localparam int MIN_RUN_LENGTH = 6;
	localparam int RUN_CNT_W      = $clog2(MAX_RUN_LENGTH + 1);

	// payload widths
	localparam int ADDR_W  = 48;
	localparam int LEN_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int HIST_W  = 64;
	localparam int TDATA_W = 56;

	// configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam logic REG_BASE_ADDRESS = 1'b0;

	// printable range and prefix characters
	localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
	localparam logic [BYTE_W-1:0] CHAR_V   = "V";
	localparam logic [BYTE_W-1:0] CHAR_A   = "A";
	localparam logic [BYTE_W-1:0] CHAR_Z   = "Z";

	// keywords, first character in the top byte
	localparam logic [71:0] KW_LONG  = "Interface";
	localparam logic [55:0] KW_SHORT = {8'h53, "ource", 8'h32};

	// one result as produced by the scan stage
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length;
	} res_t;

endpackage : prpf_pkg

`default_nettype wire

FILE: rtl/prpf_apb.sv
// prpf_apb: register file behind the configuration port (base address)
// depends on prpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module prpf_apb
	import prpf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output logic      [ADDR_W-1:0]     base_address
);

	logic [ADDR_W-1:0] base_q;
	logic              sel_base;

	// register select by index
	assign sel_base = (paddr[APB_ADDR_W-1] == REG_BASE_ADDRESS);
	assign pready   = 1'b1;

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_base) begin
			base_q <= pwdata[ADDR_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (sel_base) begin
			prdata = APB_DATA_W'(base_q);
		end
	end

	assign base_address = base_q;

endmodule : prpf_apb

`default_nettype wire

FILE: rtl/prpf_scan.sv
// prpf_scan: input register and run tracking, one byte per cycle unless the result register stalls
// depends on prpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module prpf_scan
	import prpf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] in_data,
	input  wire logic              in_last,
	input  wire logic              out_ready,
	input  wire logic [ADDR_W-1:0] base_address,
	output logic                   step,
	output res_t                   res
);

	// input register
	logic                   valid_s1;
	logic [BYTE_W-1:0]      data_s1;
	logic                   last_s1;

	// run state
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [RUN_CNT_W-1:0]   cnt_q;
	logic [HIST_W-1:0]      hist_q;
	logic                   sv_q;
	logic                   su_q;
	logic                   kl_q;
	logic                   ks_q;

	// next values
	logic                   printable;
	logic                   run_ends;
	logic [OFFSET_BITS-1:0] start_d;
	logic [RUN_CNT_W-1:0]   cnt_d;
	logic                   sv_d;
	logic                   su_d;
	logic                   kl_d;
	logic                   ks_d;
	logic                   hit_long;
	logic                   hit_short;
	logic                   report;

	logic in_fire;

	assign step     = valid_s1 && out_ready;
	assign in_ready = !valid_s1 || out_ready;
	assign in_fire  = in_valid && in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

	// keyword windows: current byte plus the history
	assign hit_long  = ({hist_q, data_s1} == KW_LONG);
	assign hit_short = ({hist_q[47:0], data_s1} == KW_SHORT);

	// per-byte update of the open run
	always_comb begin
		printable = (data_s1 >= PRINT_LO) && (data_s1 <= PRINT_HI);
		run_ends  = !printable || last_s1;
		start_d   = start_q;
		cnt_d     = cnt_q;
		sv_d      = sv_q;
		su_d      = su_q;
		kl_d      = kl_q;
		ks_d      = ks_q;
		if (printable) begin
			if (cnt_q == '0) begin
				start_d = pos_q;
				sv_d    = (data_s1 == CHAR_V);
			end else if (cnt_q == RUN_CNT_W'(1)) begin
				su_d = (data_s1 >= CHAR_A) && (data_s1 <= CHAR_Z);
			end
			if (cnt_q >= RUN_CNT_W'(8) && hit_long) begin
				kl_d = 1'b1;
			end
			if (cnt_q >= RUN_CNT_W'(6) && hit_short) begin
				ks_d = 1'b1;
			end
			if (cnt_q < RUN_CNT_W'(MAX_RUN_LENGTH)) begin
				cnt_d = cnt_q + RUN_CNT_W'(1);
			end
		end
		report = run_ends && (cnt_d >= RUN_CNT_W'(MIN_RUN_LENGTH)) &&
			(cnt_d < RUN_CNT_W'(MAX_RUN_LENGTH)) && ((sv_d && su_d) || kl_d || ks_d);
	end

	// result towards the output register
	always_comb begin
		res.valid   = valid_s1 && report;
		res.address = base_address + ADDR_W'(start_d);
		res.length  = LEN_W'(cnt_d);
	end

	// state register, advanced once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			cnt_q   <= '0;
			hist_q  <= '0;
			sv_q    <= 1'b0;
			su_q    <= 1'b0;
			kl_q    <= 1'b0;
			ks_q    <= 1'b0;
		end else if (step) begin
			if (run_ends) begin
				start_q <= '0;
				cnt_q   <= '0;
				sv_q    <= 1'b0;
				su_q    <= 1'b0;
				kl_q    <= 1'b0;
				ks_q    <= 1'b0;
			end else begin
				start_q <= start_d;
				cnt_q   <= cnt_d;
				sv_q    <= sv_d;
				su_q    <= su_d;
				kl_q    <= kl_d;
				ks_q    <= ks_d;
			end
			if (last_s1) begin
				pos_q  <= '0;
				hist_q <= '0;
			end else begin
				pos_q  <= pos_q + OFFSET_BITS'(1);
				hist_q <= {hist_q[HIST_W-BYTE_W-1:0], data_s1};
			end
		end
	end

endmodule : prpf_scan

`default_nettype wire

FILE: rtl/prpf_out.sv
// prpf_out: result register on the output stream
// depends on prpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module prpf_out
	import prpf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire res_t               res,
	output logic                    out_ready,
	output logic                    tvalid,
	input  wire logic               tready,
	output logic [TDATA_W-1:0]      tdata
);

	logic              valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;

	// free when empty or being drained this cycle
	assign out_ready = !valid_q || tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= res.valid;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			addr_q <= res.address;
			len_q  <= res.length;
		end
	end

	assign tvalid = valid_q;
	assign tdata  = {{(TDATA_W - ADDR_W - LEN_W){1'b0}}, len_q, addr_q};

endmodule : prpf_out

`default_nettype wire

FILE: rtl/printable_run_pattern_filter_core.sv
// printable_run_pattern_filter_core: top level of the printable run filter
// depends on prpf_pkg, prpf_apb, prpf_scan, prpf_out
`timescale 1ns / 1ps
`default_nettype none

// Scans a memory image streamed one byte per transfer for runs of printable
// ASCII and reports a run of 6 to 63 bytes when it starts with 'V' and an
// upper-case letter, or holds one of the two keywords. One byte is taken in
// every cycle unless the result register stalls; a byte passes an input
// register and then the result register, which offers the report of a run
// on the result stream. The only thing that slows intake is a stalled
// result register on the output stream. The base address register may only
// be written while no transfer is in flight.
module printable_run_pattern_filter_core
	import prpf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
	input  wire logic                  s_axis_tlast,   // last_byte
	// result stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [TDATA_W-1:0]    m_axis_tdata,   // [47:0] string_address,
	                                                   // [53:48] string_length
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic [ADDR_W-1:0] base_address;
	logic              out_ready;
	logic              step;
	res_t              res;

	// configuration registers
	prpf_apb u_apb (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.base_address (base_address)
	);

	// run tracking
	prpf_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_data      (s_axis_tdata),
		.in_last      (s_axis_tlast),
		.out_ready    (out_ready),
		.base_address (base_address),
		.step         (step),
		.res          (res)
	);

	// result register
	prpf_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res       (res),
		.out_ready (out_ready),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (m_axis_tdata)
	);

endmodule : printable_run_pattern_filter_core

`default_nettype wire

FILE: rtl/prpf_checker.sv
// prpf_checker: port-level checks on the printable run filter
// depends on prpf_pkg; bound to printable_run_pattern_filter_core
`timescale 1ns / 1ps
`default_nettype none

module prpf_checker
	import prpf_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [TDATA_W-1:0]    m_axis_tdata,
	input wire logic                  pready
);

	// a stalled result holds its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// reported lengths lie in the accepted window
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[53:48] >= LEN_W'(MIN_RUN_LENGTH)) &&
			(m_axis_tdata[TDATA_W-1:54] == '0))
		else $error("reported length out of range");

	// intake only stops behind a full result register
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule : prpf_checker

bind printable_run_pattern_filter_core prpf_checker u_prpf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.pready        (pready)
);

`default_nettype wire
